### hw/rtl/tcur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcur_pkg
// Shared constants and types of the three-channel ultrasonic ranger.
// ----------------------------------------------------------------------------
package tcur_pkg;

    localparam int DEF_CHANNELS   = 3;
    localparam int DEF_COUNT_BITS = 16;

    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 17;
    localparam int PERIOD_BITS    = 17;
    localparam int TRIG_LEN_BITS  = 16;
    localparam int SCALE_BITS     = 16;
    localparam int DIST_BITS      = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_RUN_ENABLE     = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_LENGTH = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_TICKS   = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_Q16      = 8'd3;

    // register reset values
    localparam logic                     RST_RUN_ENABLE     = 1'b0;
    localparam logic [TRIG_LEN_BITS-1:0] RST_TRIGGER_LENGTH = 16'd100;
    localparam logic [PERIOD_BITS-1:0]   RST_PERIOD_TICKS   = 17'd60000;
    localparam logic [SCALE_BITS-1:0]    RST_SCALE_Q16      = 16'd1114;

    // status of the modulo reduction unit
    typedef struct packed {
        logic busy;
        logic done;
    } tcur_mod_stat_t;

endpackage

### hw/rtl/tcur_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcur_mod_unit
// Bit-serial restoring remainder, one bit per cycle over several lanes in
// parallel. Reduces stored counts modulo a new period.
// ----------------------------------------------------------------------------
module tcur_mod_unit
    import tcur_pkg::*;
#(
    parameter int LANES      = DEF_CHANNELS + 1,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [COUNT_BITS:0]                 period,
    input  logic [LANES-1:0][COUNT_BITS-1:0]    values,
    output tcur_mod_stat_t                      stat,
    output logic [LANES-1:0][COUNT_BITS-1:0]    rems
);

    localparam int CW = $clog2(COUNT_BITS + 1);

    logic                               busy_reg;
    logic [CW-1:0]                      cnt_reg;
    logic [LANES-1:0][COUNT_BITS-1:0]   x_reg;
    logic [LANES-1:0][COUNT_BITS:0]     rem_reg;
    logic [LANES-1:0][COUNT_BITS:0]     rem_next;
    logic [LANES-1:0][COUNT_BITS+1:0]   shifted;
    logic                               last_step;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            // bring down the next dividend bit, subtract if it fits
            shifted[l] = {rem_reg[l], x_reg[l][COUNT_BITS-1]};
            if (shifted[l] >= (COUNT_BITS+2)'(period))
            begin
                rem_next[l] = (COUNT_BITS+1)'(shifted[l] - (COUNT_BITS+2)'(period));
            end
            else
            begin
                rem_next[l] = shifted[l][COUNT_BITS:0];
            end
            rems[l] = rem_next[l][COUNT_BITS-1:0];
        end
        last_step = busy_reg && (cnt_reg == CW'(1));
        stat.busy = busy_reg;
        stat.done = last_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(COUNT_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= values;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                x_reg[l]   <= x_reg[l] << 1;
                rem_reg[l] <= rem_next[l];
            end
        end
    end

endmodule

### hw/rtl/three_channel_ultrasonic_ranger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_ultrasonic_ranger
// Timer-tick driven echo-pulse ranger: trigger generation, echo edge service
// in round-robin arming order, and pulse width to distance scaling.
// ----------------------------------------------------------------------------
// Throughput: one tick word per cycle while the output accepts words and no
// period_ticks write or remainder reduction holds off input; the edge-service
// stage and the multiply stage are each one register deep.
// A write to period_ticks holds off input during the write and while the
// bit-serial remainder unit reduces the counter and stored starts.
// Reset: counter zero, channel zero armed, no pending edges, registers at
// their defaults, output empty.
module three_channel_ultrasonic_ranger
    import tcur_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    // input tick words
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // echo_0 .. echo_(CHANNELS-1), from bit 0 up
    input  logic [((CHANNELS+7)/8)*8-1:0]            s_tdata,
    // result words
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // trigger_0 .. trigger_(CHANNELS-1), distance_channel, distance_cm
    output logic [((CHANNELS+$clog2(CHANNELS)+DIST_BITS+7)/8)*8-1:0] m_tdata,
    // distance_valid
    output logic                                     m_tuser,
    // configuration writes
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]                  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                 cfg_data
);

    localparam int N        = COUNT_BITS;
    localparam int CH_BITS  = $clog2(CHANNELS);
    localparam int TDATA_W  = ((CHANNELS + CH_BITS + DIST_BITS + 7) / 8) * 8;
    localparam int PW       = (N + 1 > PERIOD_BITS) ? N + 1 : PERIOD_BITS;
    localparam int TW       = (N > TRIG_LEN_BITS) ? N : TRIG_LEN_BITS;
    localparam int DW       = (N > DIST_BITS) ? N : DIST_BITS;
    localparam logic [CHANNELS-1:0] ONE_HOT0 = CHANNELS'(1);

    // configuration registers
    logic                       run_reg;
    logic [TRIG_LEN_BITS-1:0]   trig_len_reg;
    logic [PERIOD_BITS-1:0]     period_reg;
    logic [SCALE_BITS-1:0]      scale_reg;

    // ranging state
    logic [N-1:0]               tick_reg, tick_next;
    logic [N-1:0]               tick_mod_reg, tick_mod_next;
    logic [CHANNELS-1:0]        armed_reg, armed_next;
    logic [CHANNELS-1:0]        pending_reg, pending_next;
    logic [CHANNELS-1:0]        prev_reg, prev_next;
    logic [N-1:0]               start_raw_reg [CHANNELS];
    logic [N-1:0]               start_mod_reg [CHANNELS];

    // stage 1: service result
    logic                       v1_reg;
    logic [CHANNELS-1:0]        trig1_reg;
    logic                       dv1_reg;
    logic [CH_BITS-1:0]         ch1_reg;
    logic [N-1:0]               width1_reg;

    // stage 2: output word
    logic                       ov_reg;
    logic [CHANNELS-1:0]        trig_o_reg;
    logic                       dv_o_reg;
    logic [CH_BITS-1:0]         ch_o_reg;
    logic [DIST_BITS-1:0]       dist_o_reg;

    logic                       cfg_fire;
    logic                       period_wr;
    logic                       s_fire;
    logic                       out_load;

    logic [PW-1:0]              p_clamp;
    logic [N:0]                 p_eff;
    logic [CHANNELS-1:0]        echo;
    logic [N-1:0]               c;
    logic [N-1:0]               cmod;
    logic [CHANNELS-1:0]        trig;
    logic [CHANNELS-1:0]        pend;
    logic                       found;
    logic [CH_BITS-1:0]         sel;
    logic [CHANNELS-1:0]        sel_hot;
    logic [CHANNELS-1:0]        nxt_hot;
    logic                       is_start;
    logic                       is_stop;
    logic [N-1:0]               s_mod;
    logic [N:0]                 wrap_width;
    logic [N-1:0]               width;
    logic [N:0]                 inc;

    logic [N+SCALE_BITS-1:0]    prod;
    logic [DW-1:0]              dist_full;
    logic [DIST_BITS-1:0]       dist_sat;

    tcur_mod_stat_t                  mod_stat;
    logic [CHANNELS:0][N-1:0]        mod_values;
    logic [CHANNELS:0][N-1:0]        mod_rems;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign period_wr = cfg_fire && (cfg_index == CFG_PERIOD_TICKS);

    assign out_load = v1_reg && (!ov_reg || m_tready);
    assign s_tready = (!v1_reg || out_load) && !mod_stat.busy
                      && !(cfg_valid && (cfg_index == CFG_PERIOD_TICKS));
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = ov_reg;
    assign m_tuser  = dv_o_reg;
    assign m_tdata  = TDATA_W'({dist_o_reg, ch_o_reg, trig_o_reg});

    // ------------------------------------------------------------------
    // period clamp and remainder unit
    // ------------------------------------------------------------------
    always_comb
    begin
        if (PW'(period_reg) < PW'(2))
        begin
            p_clamp = PW'(2);
        end
        else if (PW'(period_reg) > (PW'(1) << N))
        begin
            p_clamp = PW'(1) << N;
        end
        else
        begin
            p_clamp = PW'(period_reg);
        end
        p_eff = p_clamp[N:0];
    end

    always_comb
    begin
        mod_values[0] = tick_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            mod_values[i+1] = start_raw_reg[i];
        end
    end

    tcur_mod_unit #(
        .LANES      (CHANNELS + 1),
        .COUNT_BITS (COUNT_BITS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (period_wr),
        .period (p_eff),
        .values (mod_values),
        .stat   (mod_stat),
        .rems   (mod_rems)
    );

    // ------------------------------------------------------------------
    // edge service for one tick
    // ------------------------------------------------------------------
    always_comb
    begin
        echo = s_tdata[CHANNELS-1:0];
        c    = run_reg ? tick_reg : '0;
        cmod = run_reg ? tick_mod_reg : '0;

        trig = (run_reg && (TW'(c) < TW'(trig_len_reg))) ? armed_reg : '0;

        pend  = pending_reg | (echo ^ prev_reg);
        found = |pend;
        sel   = '0;
        // lowest pending channel wins
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (pend[i])
            begin
                sel = CH_BITS'(i);
            end
        end
        sel_hot = ONE_HOT0 << sel;
        nxt_hot = (sel == CH_BITS'(CHANNELS - 1)) ? ONE_HOT0 : (sel_hot << 1);

        is_start = found && echo[sel];
        is_stop  = found && !echo[sel];

        // both operands already below the period
        s_mod      = start_mod_reg[sel];
        wrap_width = ({1'b0, cmod} + p_eff) - {1'b0, s_mod};
        width      = (cmod >= s_mod) ? (cmod - s_mod) : wrap_width[N-1:0];

        inc = {1'b0, c} + (N+1)'(1);

        tick_next     = tick_reg;
        tick_mod_next = tick_mod_reg;
        armed_next    = armed_reg;
        pending_next  = pending_reg;
        prev_next     = prev_reg;

        if (s_fire)
        begin
            pending_next = pend & ~(found ? sel_hot : '0);
            prev_next    = echo;
            if (is_start)
            begin
                armed_next = (armed_reg & ~sel_hot) | nxt_hot;
            end
            if (run_reg)
            begin
                tick_next = (inc >= p_eff) ? '0 : inc[N-1:0];
            end
            else
            begin
                tick_next = '0;
            end
            // advanced counter is always below the period
            tick_mod_next = tick_next;
        end
        else if (mod_stat.done)
        begin
            tick_mod_next = mod_rems[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= RST_RUN_ENABLE;
            trig_len_reg <= RST_TRIGGER_LENGTH;
            period_reg   <= RST_PERIOD_TICKS;
            scale_reg    <= RST_SCALE_Q16;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_RUN_ENABLE:     run_reg      <= cfg_data[0];
                CFG_TRIGGER_LENGTH: trig_len_reg <= cfg_data[TRIG_LEN_BITS-1:0];
                CFG_PERIOD_TICKS:   period_reg   <= cfg_data[PERIOD_BITS-1:0];
                CFG_SCALE_Q16:      scale_reg    <= cfg_data[SCALE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            tick_mod_reg <= '0;
            armed_reg    <= ONE_HOT0;
            pending_reg  <= '0;
            prev_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                start_raw_reg[i] <= '0;
                start_mod_reg[i] <= '0;
            end
        end
        else
        begin
            tick_reg     <= tick_next;
            tick_mod_reg <= tick_mod_next;
            armed_reg    <= armed_next;
            pending_reg  <= pending_next;
            prev_reg     <= prev_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (s_fire && is_start && (sel == CH_BITS'(i)))
                begin
                    start_raw_reg[i] <= c;
                    start_mod_reg[i] <= cmod;
                end
                else if (mod_stat.done)
                begin
                    start_mod_reg[i] <= mod_rems[i+1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1 register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            v1_reg <= 1'b1;
        end
        else if (out_load)
        begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            trig1_reg  <= trig;
            dv1_reg    <= is_stop;
            ch1_reg    <= is_stop ? sel : '0;
            width1_reg <= is_stop ? width : '0;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: scale to centimetres, saturate
    // ------------------------------------------------------------------
    always_comb
    begin
        prod      = (N+SCALE_BITS)'(width1_reg) * (N+SCALE_BITS)'(scale_reg);
        dist_full = DW'(prod >> SCALE_BITS);
        if (dist_full > DW'(16'hFFFF))
        begin
            dist_sat = 16'hFFFF;
        end
        else
        begin
            dist_sat = dist_full[DIST_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            trig_o_reg <= trig1_reg;
            dv_o_reg   <= dv1_reg;
            ch_o_reg   <= ch1_reg;
            dist_o_reg <= dist_sat;
        end
    end

endmodule

### tb/three_channel_ultrasonic_ranger_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_ultrasonic_ranger_test
// Self-checking bench for the three-channel ultrasonic ranger. A queue of echo
// tick words feeds a clocked driver; a clocked monitor runs a tick-accurate
// ranging predictor on every accepted word and checks each result word field
// by field. Directed cases cover idle operation, period clamping, counter
// wrap, lowered periods and multiple pending edges. Randomized echo pulse
// trains follow under varied register settings and flow-control patterns.
// ----------------------------------------------------------------------------
module three_channel_ultrasonic_ranger_test;
    import tcur_pkg::*;

    localparam int HANG_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]  trig;
        logic        valid;
        logic [1:0]  chan;
        logic [15:0] cm;
    } ranger_word_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [7:0]               s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [23:0]              m_tdata;
    logic                     m_tuser;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // stimulus and expectations
    logic [2:0]   tick_q[$];
    ranger_word_t range_q[$];
    logic [2:0]   echo_level = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_phase     = 1'b0;
    int hold_cnt       = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    // predictor state
    logic        pr_run;
    logic [15:0] pr_trig_len;
    logic [16:0] pr_period;
    logic [15:0] pr_scale;
    logic [15:0] pr_count;
    logic [2:0]  pr_armed;
    logic [2:0]  pr_pending;
    logic [2:0]  pr_prev_echo;
    logic [15:0] pr_start[3];

    three_channel_ultrasonic_ranger DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // One tick of the ranger: triggers, edge service, then counter advance.
    function automatic ranger_word_t predict_range(input logic [2:0] echo);
        ranger_word_t     w;
        int unsigned      eff;
        int unsigned      c;
        int unsigned      width;
        longint unsigned  prod;
        bit               served;
        begin
            w      = '0;
            served = 1'b0;
            eff    = 32'(pr_period);
            if (eff < 2)
                eff = 2;
            if (eff > 65536)
                eff = 65536;
            c = pr_run ? 32'(pr_count) : 32'd0;
            for (int i = 0; i < 3; i++)
                w.trig[i] = pr_run && pr_armed[i] && (c < pr_trig_len);
            pr_pending   = pr_pending | (echo ^ pr_prev_echo);
            pr_prev_echo = echo;
            for (int i = 0; i < 3; i++)
            begin
                if (!served && pr_pending[i])
                begin
                    served        = 1'b1;
                    pr_pending[i] = 1'b0;
                    if (echo[i])
                    begin
                        pr_start[i]            = c[15:0];
                        pr_armed[i]            = 1'b0;
                        pr_armed[(i + 1) % 3]  = 1'b1;
                    end
                    else
                    begin
                        // width modulo the period absorbs counter wrap
                        width   = ((c % eff) + eff - (pr_start[i] % eff)) % eff;
                        prod    = longint'(width) * pr_scale;
                        w.valid = 1'b1;
                        w.chan  = i[1:0];
                        w.cm    = (prod >> 16) > 65535 ? 16'hFFFF : prod[31:16];
                    end
                end
            end
            if (!pr_run)
                pr_count = '0;
            else if (c + 1 >= eff)
                pr_count = '0;
            else
                pr_count = c[15:0] + 16'd1;
            return w;
        end
    endfunction

    task automatic report(input string field, input int unsigned want, input int unsigned got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (tick_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, tick_q.pop_front()};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with a long hold-off at the start of a pressure phase
    always @(posedge clk)
    begin
        if (hold_phase && hold_cnt < HOLD_CYCLES)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            if (!hold_phase)
                hold_cnt <= 0;
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor: track registers, predict each accepted tick, check results
    always @(posedge clk)
    begin
        ranger_word_t want;
        ranger_word_t got;
        if (!rst_n)
        begin
            pr_run       = RST_RUN_ENABLE;
            pr_trig_len  = RST_TRIGGER_LENGTH;
            pr_period    = RST_PERIOD_TICKS;
            pr_scale     = RST_SCALE_Q16;
            pr_count     = '0;
            pr_armed     = 3'b001;
            pr_pending   = '0;
            pr_prev_echo = '0;
            for (int i = 0; i < 3; i++)
                pr_start[i] = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RUN_ENABLE:     pr_run      = cfg_data[0];
                    CFG_TRIGGER_LENGTH: pr_trig_len = cfg_data[15:0];
                    CFG_PERIOD_TICKS:   pr_period   = cfg_data;
                    CFG_SCALE_Q16:      pr_scale    = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                range_q.push_back(predict_range(s_tdata[2:0]));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[2:0], m_tuser, m_tdata[4:3], m_tdata[20:5]};
                if (range_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none actual %0h",
                             $time, got);
                end
                else
                begin
                    want = range_q.pop_front();
                    if (got.trig !== want.trig)
                        report("trigger", want.trig, got.trig);
                    if (got.valid !== want.valid)
                        report("distance_valid", want.valid, got.valid);
                    if (got.chan !== want.chan)
                        report("distance_channel", want.chan, got.chan);
                    if (got.cm !== want.cm)
                        report("distance_cm", want.cm, got.cm);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("FAIL three_channel_ultrasonic_ranger");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_ticks(input logic [2:0] lvl, input int n);
        repeat (n)
            tick_q.push_back(lvl);
    endtask

    // sample at the falling edge, after the driver and monitor have settled
    task automatic wait_drain();
        while (tick_q.size() != 0 || s_tvalid || range_q.size() != 0)
            @(negedge clk);
    endtask

    // Echo pulse trains: mostly clean pulses, some simultaneous, some noise.
    task automatic queue_echo_traffic(input int n);
        int         made;
        int         kind;
        int         ch;
        int         len;
        logic [2:0] mask;
        made = 0;
        while (made < n)
        begin
            kind = $urandom_range(9);
            if (kind <= 6)
            begin
                ch  = $urandom_range(2);
                len = $urandom_range(0, 12);
                echo_level[ch] = 1'b1;
                push_ticks(echo_level, len + 1);
                echo_level[ch] = 1'b0;
                push_ticks(echo_level, 1);
                made += len + 2;
                len = $urandom_range(0, 6);
                push_ticks(echo_level, len);
                made += len;
            end
            else if (kind == 7)
            begin
                mask = 3'($urandom_range(1, 7));
                len  = $urandom_range(0, 8);
                echo_level = echo_level | mask;
                push_ticks(echo_level, len + 1);
                echo_level = '0;
                push_ticks(echo_level, 2);
                made += len + 3;
            end
            else
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    echo_level = 3'($urandom_range(7));
                    push_ticks(echo_level, 1);
                end
                made += len;
            end
        end
    endtask

    task automatic pick_settings();
        logic [CFG_DATA_BITS-1:0] d;
        d    = CFG_DATA_BITS'($urandom_range(0, 17'h1FFFF));
        d[0] = ($urandom_range(7) != 0);
        write_reg(CFG_RUN_ENABLE, d);
        case ($urandom_range(3))
            0:       d = CFG_DATA_BITS'($urandom_range(0, 8));
            3:       d = CFG_DATA_BITS'($urandom_range(0, 17'h1FFFF));
            default: d = CFG_DATA_BITS'($urandom_range(0, 60));
        endcase
        write_reg(CFG_TRIGGER_LENGTH, d);
        if ($urandom_range(5) == 0)
            d = CFG_DATA_BITS'($urandom_range(0, 17'h1FFFF));
        else
            d = CFG_DATA_BITS'($urandom_range(2, 150));
        write_reg(CFG_PERIOD_TICKS, d);
        write_reg(CFG_SCALE_Q16, CFG_DATA_BITS'($urandom_range(0, 65535)));
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_BITS'($urandom_range(4, 255)),
                      CFG_DATA_BITS'($urandom_range(0, 17'h1FFFF)));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: block idle, all lines rise together, then all fall
        push_ticks(3'b000, 1);
        push_ticks(3'b111, 3);
        push_ticks(3'b000, 1);
        wait_drain();

        // short period, pulse on sensor zero spanning a counter wrap
        write_reg(CFG_RUN_ENABLE, 17'd1);
        write_reg(CFG_TRIGGER_LENGTH, 17'd3);
        write_reg(CFG_PERIOD_TICKS, 17'd8);
        write_reg(CFG_SCALE_Q16, 17'hFFFF);
        push_ticks(3'b001, 9);
        push_ticks(3'b000, 1);
        wait_drain();

        // period above the counter range, trigger length 16'hFFFF, below the clamped period
        write_reg(CFG_PERIOD_TICKS, 17'h1FFFF);
        write_reg(CFG_TRIGGER_LENGTH, 17'hFFFF);
        push_ticks(3'b000, 2);
        push_ticks(3'b100, 1);
        wait_drain();

        // stop the block mid-pulse; the fall measures against a zero counter
        write_reg(CFG_RUN_ENABLE, 17'h1FFFE);
        push_ticks(3'b000, 1);
        wait_drain();

        // periods below two, zero trigger length, unknown register indexes
        write_reg(CFG_PERIOD_TICKS, 17'd0);
        write_reg(CFG_PERIOD_TICKS, 17'd1);
        write_reg(CFG_TRIGGER_LENGTH, 17'd0);
        write_reg(CFG_SCALE_Q16, 17'd1);
        write_reg(CFG_RUN_ENABLE, 17'd1);
        write_reg(8'd4, 17'h1FFFF);
        write_reg(8'd255, 17'd0);
        push_ticks(3'b001, 1);
        push_ticks(3'b000, 1);
        push_ticks(3'b011, 1);
        push_ticks(3'b000, 1);
        wait_drain();

        // lower the period below the running counter, then close the pulse
        write_reg(CFG_PERIOD_TICKS, 17'd1000);
        write_reg(CFG_SCALE_Q16, 17'd40000);
        push_ticks(3'b000, 12);
        push_ticks(3'b010, 1);
        wait_drain();
        write_reg(CFG_PERIOD_TICKS, 17'd5);
        push_ticks(3'b000, 1);
        wait_drain();

        for (int mode = 0; mode < 4; mode++)
        begin
            for (int ph = 0; ph < 2; ph++)
            begin
                src_idle_pct   = (mode == 1) ? 66 : (mode == 3) ? 6 : 0;
                sink_stall_pct = (mode == 2) ? 66 : (mode == 3) ? 6 : 0;
                pick_settings();
                // stall the output while ticks keep coming
                hold_phase = (mode == 0 && ph == 0);
                queue_echo_traffic(70);
                wait_drain();
                hold_phase = 1'b0;
            end
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        wait_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && range_q.size() == 0)
            $display("PASS three_channel_ultrasonic_ranger");
        else
            $display("FAIL three_channel_ultrasonic_ranger");
        $finish;
    end

endmodule
